### design/sbcd_pkg.sv
// Shared types and constants for the slot batch claim and drain block.
`default_nettype none

package sbcd_pkg;

    // Width of a slot number on the ports and of the active count register.
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;
    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Active slot count after reset.
    localparam logic [COUNT_W-1:0] SLOTS_RESET = 6'd32;

    // Register indexes on the configuration port.
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    // Command kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_CLAIM       = 3'd0,
        MODE_COMMIT      = 3'd1,
        MODE_DRAIN_START = 3'd2,
        MODE_DRAIN_NEXT  = 3'd3,
        MODE_DRAIN_END   = 3'd4,
        MODE_DISCARD     = 3'd5
    } mode_t;

    // One registered command word.
    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot_index;
    } cmd_t;

    // Configuration control passed to the slot state.
    typedef struct packed {
        logic               reinit;
        logic [COUNT_W-1:0] slots;
    } cfg_t;

    // One result word.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

`default_nettype wire

### design/slot_batch_claim_and_drain.sv
// Top level of the slot batch claim and drain block: command port, APB register, slot state.
// A command word is registered in cmd_reg and its result word in the core's result register.
// Throughput: one command word per cycle; busy is never raised.
// Each result word is shown for one cycle with done high and cannot be stalled.
// Reset (rst_n low, asynchronous) sets 32 active slots, all empty, and an idle drain.
// A write of slots_in_use re-initializes every active slot as empty and clears all other slot state.
`default_nettype none

module slot_batch_claim_and_drain #(
    parameter int MAX_SLOTS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Command port.
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sbcd_pkg::MODE_W-1:0]   mode,
    input  wire logic [sbcd_pkg::SLOT_W-1:0]   slot_index,
    // Result port.
    output logic                               done,
    output logic                               found,
    output logic [sbcd_pkg::SLOT_W-1:0]        slot_out,
    // APB configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sbcd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sbcd_pkg::DATA_W-1:0]   pwdata,
    output logic [sbcd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [sbcd_pkg::COUNT_W-1:0] slots_reg, slots_next;
    sbcd_pkg::cmd_t               cmd_reg,   cmd_next;
    sbcd_pkg::cfg_t               cfg;
    sbcd_pkg::result_t            result;

    logic                         reg_wr;
    logic [sbcd_pkg::COUNT_W-1:0] wr_count;

    // The block takes a command word in every cycle, so it never reports busy.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // A write completes in the access phase; only register index zero exists.
    assign reg_wr   = psel && penable && pwrite && pready &&
                      (paddr[2] == sbcd_pkg::REG_SLOTS_IN_USE);
    assign wr_count = pwdata[sbcd_pkg::COUNT_W-1:0];

    always_comb
    begin
        slots_next = slots_reg;
        if (reg_wr)
        begin
            // Counts above the slot capacity saturate to the capacity.
            if (wr_count > sbcd_pkg::COUNT_W'(MAX_SLOTS))
            begin
                slots_next = sbcd_pkg::COUNT_W'(MAX_SLOTS);
            end
            else
            begin
                slots_next = wr_count;
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sbcd_pkg::REG_SLOTS_IN_USE)
        begin
            prdata[sbcd_pkg::COUNT_W-1:0] = slots_reg;
        end
    end

    // The command word is registered on acceptance; the state logic works from this copy.
    always_comb
    begin
        cmd_next.valid      = start && !busy;
        cmd_next.mode       = mode;
        cmd_next.slot_index = slot_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= sbcd_pkg::SLOTS_RESET;
            cmd_reg   <= '0;
        end
        else
        begin
            slots_reg <= slots_next;
            cmd_reg   <= cmd_next;
        end
    end

    // The re-initialization uses the count that was just written.
    assign cfg.reinit = reg_wr;
    assign cfg.slots  = reg_wr ? slots_next : slots_reg;

    sbcd_core #(.MAX_SLOTS(MAX_SLOTS)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd_reg),
        .result (result)
    );

    assign done     = result.done;
    assign found    = result.found;
    assign slot_out = result.slot;

endmodule

`default_nettype wire

### design/sbcd_ffs.sv
// Find-first-set: isolates the lowest set bit of a vector and encodes its position.
`default_nettype none

module sbcd_ffs #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0]              vec,
    output logic                               any,
    output logic [WIDTH-1:0]                   lowbit,
    output logic [sbcd_pkg::SLOT_W-1:0]        index
);

    always_comb
    begin
        any    = |vec;
        lowbit = vec & (~vec + WIDTH'(1));
        index  = '0;
        // Each output bit is the OR of the one-hot positions that carry it.
        for (int i = 0; i < WIDTH; i++)
        begin
            if (lowbit[i])
            begin
                index = index | sbcd_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### design/sbcd_core.sv
// Slot state bitmaps, per-command update logic and the result register.
`default_nettype none

module sbcd_core #(
    parameter int MAX_SLOTS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbcd_pkg::cfg_t    cfg,
    input  wire sbcd_pkg::cmd_t    cmd,
    output sbcd_pkg::result_t      result
);

    logic [MAX_SLOTS-1:0] empty_reg,   empty_next;
    logic [MAX_SLOTS-1:0] pending_reg, pending_next;
    logic [MAX_SLOTS-1:0] full_reg,    full_next;
    logic [MAX_SLOTS-1:0] visit_reg,   visit_next;
    logic [MAX_SLOTS-1:0] release_reg, release_next;
    sbcd_pkg::result_t    result_reg,  result_next;

    logic [MAX_SLOTS-1:0] active_mask;
    logic [MAX_SLOTS-1:0] sel;
    logic [MAX_SLOTS-1:0] claim_vec;
    logic [MAX_SLOTS-1:0] drain_vec;
    logic [MAX_SLOTS-1:0] claim_bit;
    logic [MAX_SLOTS-1:0] drain_bit;
    logic [MAX_SLOTS-1:0] freed;
    logic                 claim_any;
    logic                 drain_any;
    logic [sbcd_pkg::SLOT_W-1:0] claim_idx;
    logic [sbcd_pkg::SLOT_W-1:0] drain_idx;

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            active_mask[i] = (sbcd_pkg::COUNT_W'(i) < cfg.slots);
            sel[i]         = (cmd.slot_index == sbcd_pkg::SLOT_W'(i));
        end
    end

    assign claim_vec = empty_reg & active_mask;
    assign drain_vec = visit_reg & full_reg & active_mask;
    assign freed     = release_reg & full_reg & active_mask;

    sbcd_ffs #(.WIDTH(MAX_SLOTS)) u_claim_ffs (
        .vec    (claim_vec),
        .any    (claim_any),
        .lowbit (claim_bit),
        .index  (claim_idx)
    );

    sbcd_ffs #(.WIDTH(MAX_SLOTS)) u_drain_ffs (
        .vec    (drain_vec),
        .any    (drain_any),
        .lowbit (drain_bit),
        .index  (drain_idx)
    );

    always_comb
    begin
        empty_next   = empty_reg;
        pending_next = pending_reg;
        full_next    = full_reg;
        visit_next   = visit_reg;
        release_next = release_reg;
        result_next  = '0;

        if (cfg.reinit)
        begin
            empty_next   = active_mask;
            pending_next = '0;
            full_next    = '0;
            visit_next   = '0;
            release_next = '0;
        end
        else if (cmd.valid)
        begin
            result_next.done = 1'b1;
            case (cmd.mode)
                sbcd_pkg::MODE_CLAIM:
                begin
                    if (claim_any)
                    begin
                        empty_next        = empty_reg & ~claim_bit;
                        pending_next      = pending_reg | claim_bit;
                        result_next.found = 1'b1;
                        result_next.slot  = claim_idx;
                    end
                end
                sbcd_pkg::MODE_COMMIT:
                begin
                    // A commit to a slot that is not pending changes nothing.
                    if (|(pending_reg & sel))
                    begin
                        pending_next      = pending_reg & ~sel;
                        full_next         = full_reg | sel;
                        result_next.found = 1'b1;
                    end
                end
                sbcd_pkg::MODE_DRAIN_START:
                begin
                    visit_next        = ~empty_reg & active_mask;
                    release_next      = '0;
                    result_next.found = |(~empty_reg & active_mask);
                end
                sbcd_pkg::MODE_DRAIN_NEXT:
                begin
                    if (drain_any)
                    begin
                        visit_next = visit_reg & ~(drain_bit | (drain_bit - MAX_SLOTS'(1)));
                        release_next      = release_reg | drain_bit;
                        result_next.found = 1'b1;
                        result_next.slot  = drain_idx;
                    end
                    else
                    begin
                        visit_next = '0;
                    end
                end
                sbcd_pkg::MODE_DRAIN_END:
                begin
                    full_next         = full_reg & ~freed;
                    empty_next        = empty_reg | freed;
                    visit_next        = '0;
                    release_next      = '0;
                    result_next.found = |freed;
                end
                sbcd_pkg::MODE_DISCARD:
                begin
                    pending_next = '0;
                    empty_next   = active_mask & ~full_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg   <= '1;
            pending_reg <= '0;
            full_reg    <= '0;
            visit_reg   <= '0;
            release_reg <= '0;
            result_reg  <= '0;
        end
        else
        begin
            empty_reg   <= empty_next;
            pending_reg <= pending_next;
            full_reg    <= full_next;
            visit_reg   <= visit_next;
            release_reg <= release_next;
            result_reg  <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
